>>> rtl/core/idw_pkg.sv
package idw_pkg;

    localparam int COORD_W     = 24;
    localparam int VALUE_W     = 32;
    localparam int PEXP_W      = 8;
    localparam int RAD_W       = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int DIMS_MAX    = 3;
    localparam int WSUM_W      = 48;
    localparam int WVS_W       = 64;
    localparam int MANT_W      = 31;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 6;
    localparam int ROM_DEPTH   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int KEPT_LIMIT  = 131071;

    localparam int DEF_DIMENSIONS = 2;
    localparam int DEF_MAX_POINTS = 65536;

    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(25);
    localparam logic [STEP_W-1:0] LOG_LAST  = STEP_W'(15);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(63);

    localparam logic              FUNC_TARGET = 1'b0;
    localparam logic              FUNC_POINT  = 1'b1;

    localparam logic [PEXP_W-1:0] POWER_RESET  = PEXP_W'(32);
    localparam logic              RADIUS_RESET = 1'b0;
    localparam logic [RAD_W-1:0]  MAXR_RESET   = RAD_W'(33554431);
    localparam logic [RAD_W-1:0]  EHD_RESET    = RAD_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_EXPONENT  = 2'd0,
        REG_RADIUS_ENABLE   = 2'd1,
        REG_MAX_RADIUS      = 2'd2,
        REG_EXACT_HIT_DIST  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PEXP_W-1:0] power_exponent;
        logic              radius_enable;
        logic [RAD_W-1:0]  max_radius;
        logic [RAD_W-1:0]  exact_hit_distance;
    } cfg_t;

    typedef struct packed {
        logic                              is_target;
        logic                              is_point;
        logic                              last;
        logic [DIMS_MAX-1:0][COORD_W-1:0]  coord;
        logic [VALUE_W-1:0]                value;
    } queue_entry_t;

    typedef logic [ROM_DEPTH-1:0][MANT_W-1:0] rom_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30, k = 1..16
    function automatic rom_t build_exp_rom();
        rom_t        rom;
        logic [63:0] t;
        t = isqrt64(64'h2000_0000_0000_0000);
        rom[0] = t[MANT_W-1:0];
        for (int k = 1; k < ROM_DEPTH; k++)
        begin
            t = isqrt64({3'b000, rom[k-1], 30'b0});
            rom[k] = t[MANT_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t EXP_ROM = build_exp_rom();

endpackage

>>> rtl/core/idw_item_if.sv
interface idw_item_if;
    import idw_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [VALUE_W-1:0] sample_value;
    logic               usable;
    logic               last;

    modport source (
        output valid, func, coord_x, coord_y, coord_z, sample_value, usable, last,
        input  ready
    );
    modport sink (
        input  valid, func, coord_x, coord_y, coord_z, sample_value, usable, last,
        output ready
    );
endinterface

>>> rtl/core/idw_result_if.sv
interface idw_result_if;
    import idw_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] estimate;
    logic               missing;

    modport source (output valid, estimate, missing, input ready);
    modport sink (input valid, estimate, missing, output ready);
endinterface

>>> rtl/core/idw_cfg_if.sv
interface idw_cfg_if;
    import idw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/idw_front.sv
module idw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    idw_item_if.sink              items,
    output idw_pkg::queue_entry_t q_entry,
    output logic                  q_valid,
    input  logic                  q_pop
);
    import idw_pkg::*;

    queue_entry_t mem_reg [QUEUE_DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    queue_entry_t in_entry;
    logic         push;

    always_comb
    begin
        in_entry.is_target = (items.func == FUNC_TARGET);
        in_entry.is_point  = (items.func == FUNC_POINT) && items.usable;
        in_entry.last      = items.last;
        in_entry.coord     = {items.coord_z, items.coord_y, items.coord_x};
        in_entry.value     = items.sample_value;
    end

    assign items.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push        = items.valid && items.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign q_entry     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

>>> rtl/core/idw_back.sv
module idw_back #(
    parameter int DIMENSIONS = idw_pkg::DEF_DIMENSIONS,
    parameter int MAX_POINTS = idw_pkg::DEF_MAX_POINTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  idw_pkg::cfg_t         cfg,
    input  idw_pkg::queue_entry_t q_entry,
    input  logic                  q_valid,
    output logic                  q_pop,
    idw_result_if.source          results
);
    import idw_pkg::*;

    localparam int KEPT_CAP = (MAX_POINTS < KEPT_LIMIT) ? MAX_POINTS : KEPT_LIMIT;
    localparam int KEPT_W   = $clog2(KEPT_CAP + 1);
    localparam logic [STEP_W-1:0] DIM_LAST = STEP_W'(DIMENSIONS - 1);
    localparam logic signed [64:0] WVS_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] WVS_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'd1,
        ST_SQ_MUL  = 18'd2,
        ST_SQ_ACC  = 18'd4,
        ST_SQRT    = 18'd8,
        ST_CHECK   = 18'd16,
        ST_NORM    = 18'd32,
        ST_LOG_MUL = 18'd64,
        ST_LOG_ACC = 18'd128,
        ST_GCALC   = 18'd256,
        ST_EXP_MUL = 18'd512,
        ST_EXP_ACC = 18'd1024,
        ST_WEIGHT  = 18'd2048,
        ST_VMUL    = 18'd4096,
        ST_ACCUM   = 18'd8192,
        ST_FINISH  = 18'd16384,
        ST_DIV     = 18'd32768,
        ST_ROUND   = 18'd65536,
        ST_EMIT    = 18'd131072
    } state_t;

    state_t                           state_reg;
    logic [STEP_W-1:0]                step_reg;
    logic [DIMS_MAX-1:0][COORD_W-1:0] target_reg;
    logic [WSUM_W-1:0]                wsum_reg;
    logic signed [WVS_W-1:0]          wvs_reg;
    logic [KEPT_W-1:0]                kept_reg;
    logic                             exact_reg;
    logic [VALUE_W-1:0]               exact_val_reg;
    logic                             out_valid_reg;
    logic [VALUE_W-1:0]               out_est_reg;
    logic                             out_miss_reg;

    queue_entry_t                     item_reg;
    logic [51:0]                      sq_acc_reg;
    logic [25:0]                      root_reg;
    logic [27:0]                      rem_reg;
    logic [RAD_W-1:0]                 dist_reg;
    logic [4:0]                       nsh_reg;
    logic [MANT_W-1:0]                m_reg;
    logic [FRAC_W-1:0]                frac_reg;
    logic signed [11:0]               gi_reg;
    logic [FRAC_W-1:0]                gf_reg;
    logic [31:0]                      w_reg;
    logic [63:0]                      prod_reg;
    logic [63:0]                      num_reg;
    logic [WSUM_W-1:0]                drem_reg;
    logic                             neg_reg;
    logic [VALUE_W-1:0]               res_est_reg;
    logic                             res_miss_reg;

    logic [1:0]          dim_idx;
    logic signed [24:0]  diff;
    logic [24:0]         absd;
    logic [29:0]         rem_sh;
    logic [29:0]         trial;
    logic                sqrt_ge;
    logic [31:0]         log_t;
    logic signed [5:0]   lint;
    logic signed [21:0]  l_val;
    logic signed [30:0]  pl;
    logic signed [31:0]  g_val;
    logic                exp_bit;
    logic signed [12:0]  sh_amt;
    logic [31:0]         w_calc;
    logic [31:0]         vabs;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [48:0]         ws_sum;
    logic signed [63:0]  pterm;
    logic signed [64:0]  wvs_sum;
    logic [62:0]         wvs_abs;
    logic [48:0]         div_rs;
    logic                div_ge;
    logic [VALUE_W-1:0]  q_sat;
    logic                out_free;
    logic                point_go;
    logic                far;
    logic                hit;
    state_t              done_state;

    assign dim_idx = step_reg[1:0];
    assign diff    = {item_reg.coord[dim_idx][COORD_W-1], item_reg.coord[dim_idx]}
                   - {target_reg[dim_idx][COORD_W-1], target_reg[dim_idx]};
    assign absd    = diff[24] ? 25'(-diff) : diff;

    assign rem_sh  = {rem_reg, sq_acc_reg[51:50]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sqrt_ge = (rem_sh >= trial);

    assign log_t   = prod_reg[61:30];
    assign lint    = 6'sd16 - $signed({1'b0, nsh_reg});
    assign l_val   = {lint, frac_reg};
    assign pl      = 31'($signed({1'b0, cfg.power_exponent})) * 31'(l_val);
    assign g_val   = 32'sd16777216 - 32'(pl);

    assign exp_bit = gf_reg[~step_reg[3:0]];
    assign sh_amt  = 13'sd30 - $signed({gi_reg[11], gi_reg});

    always_comb
    begin
        if (gi_reg >= 12'sd32)
        begin
            w_calc = '1;
        end
        else if (gi_reg == 12'sd31)
        begin
            w_calc = {m_reg, 1'b0};
        end
        else if (sh_amt > 13'sd30)
        begin
            w_calc = '0;
        end
        else
        begin
            w_calc = {1'b0, m_reg >> sh_amt[4:0]};
        end
    end

    assign vabs = item_reg.value[VALUE_W-1] ? 32'(-item_reg.value) : item_reg.value;

    always_comb
    begin
        case (state_reg)
            ST_LOG_MUL:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_EXP_MUL:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = exp_bit ? {1'b0, EXP_ROM[step_reg[3:0]]} : 32'h4000_0000;
            end
            ST_VMUL:
            begin
                mul_a = vabs;
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = {7'b0, absd};
                mul_b = {7'b0, absd};
            end
        endcase
    end

    assign ws_sum  = {1'b0, wsum_reg} + {17'b0, w_reg};
    assign pterm   = item_reg.value[VALUE_W-1] ? -$signed(prod_reg) : $signed(prod_reg);
    assign wvs_sum = {wvs_reg[WVS_W-1], wvs_reg} + {pterm[63], pterm};
    assign wvs_abs = wvs_reg[WVS_W-1] ? 63'(-wvs_reg) : wvs_reg[62:0];

    assign div_rs  = {drem_reg, num_reg[63]};
    assign div_ge  = (div_rs >= {1'b0, wsum_reg});

    always_comb
    begin
        if (neg_reg)
        begin
            q_sat = (num_reg > 64'h8000_0000) ? 32'h8000_0000 : 32'(-num_reg[31:0]);
        end
        else
        begin
            q_sat = (num_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_reg[31:0];
        end
    end

    assign out_free   = !out_valid_reg || results.ready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign point_go   = q_entry.is_point && !exact_reg && (kept_reg < KEPT_W'(KEPT_CAP));
    assign far        = cfg.radius_enable && (root_reg[24:0] > cfg.max_radius);
    assign hit        = (root_reg[24:0] == '0) || (root_reg[24:0] < cfg.exact_hit_distance);
    assign done_state = item_reg.last ? ST_FINISH : ST_IDLE;

    assign results.valid    = out_valid_reg;
    assign results.estimate = out_est_reg;
    assign results.missing  = out_miss_reg;

    // control and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            target_reg    <= '0;
            wsum_reg      <= '0;
            wvs_reg       <= '0;
            kept_reg      <= '0;
            exact_reg     <= 1'b0;
            exact_val_reg <= '0;
            out_valid_reg <= 1'b0;
            out_est_reg   <= '0;
            out_miss_reg  <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        step_reg <= '0;
                        if (q_entry.is_target)
                        begin
                            target_reg    <= q_entry.coord;
                            wsum_reg      <= '0;
                            wvs_reg       <= '0;
                            kept_reg      <= '0;
                            exact_reg     <= 1'b0;
                            exact_val_reg <= '0;
                            state_reg     <= q_entry.last ? ST_FINISH : ST_IDLE;
                        end
                        else if (point_go)
                        begin
                            state_reg <= ST_SQ_MUL;
                        end
                        else
                        begin
                            state_reg <= q_entry.last ? ST_FINISH : ST_IDLE;
                        end
                    end
                end
                ST_SQ_MUL:
                begin
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    if (step_reg == DIM_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT:
                begin
                    if (step_reg == SQRT_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_CHECK:
                begin
                    if (far)
                    begin
                        state_reg <= done_state;
                    end
                    else if (hit)
                    begin
                        exact_reg     <= 1'b1;
                        exact_val_reg <= item_reg.value;
                        kept_reg      <= KEPT_W'(1);
                        state_reg     <= done_state;
                    end
                    else
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (dist_reg[RAD_W-1])
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_LOG_MUL;
                    end
                end
                ST_LOG_MUL:
                begin
                    state_reg <= ST_LOG_ACC;
                end
                ST_LOG_ACC:
                begin
                    if (step_reg == LOG_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_GCALC;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_LOG_MUL;
                    end
                end
                ST_GCALC:
                begin
                    state_reg <= ST_EXP_MUL;
                end
                ST_EXP_MUL:
                begin
                    state_reg <= ST_EXP_ACC;
                end
                ST_EXP_ACC:
                begin
                    if (step_reg == LOG_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_WEIGHT;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_EXP_MUL;
                    end
                end
                ST_WEIGHT:
                begin
                    state_reg <= ST_VMUL;
                end
                ST_VMUL:
                begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    wsum_reg <= ws_sum[48] ? '1 : ws_sum[WSUM_W-1:0];
                    if (wvs_sum > WVS_MAX)
                    begin
                        wvs_reg <= WVS_MAX[WVS_W-1:0];
                    end
                    else if (wvs_sum < WVS_MIN)
                    begin
                        wvs_reg <= WVS_MIN[WVS_W-1:0];
                    end
                    else
                    begin
                        wvs_reg <= wvs_sum[WVS_W-1:0];
                    end
                    kept_reg  <= kept_reg + KEPT_W'(1);
                    state_reg <= done_state;
                end
                ST_FINISH:
                begin
                    step_reg <= '0;
                    if (exact_reg || (kept_reg == '0) || (wsum_reg == '0))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == DIV_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_ROUND:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_est_reg   <= res_est_reg;
                        out_miss_reg  <= res_miss_reg;
                        wsum_reg      <= '0;
                        wvs_reg       <= '0;
                        kept_reg      <= '0;
                        exact_reg     <= 1'b0;
                        exact_val_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // shared multiplier and working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a * mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    item_reg   <= q_entry;
                    sq_acc_reg <= '0;
                end
            end
            ST_SQ_ACC:
            begin
                sq_acc_reg <= sq_acc_reg + prod_reg[51:0];
                root_reg   <= '0;
                rem_reg    <= '0;
            end
            ST_SQRT:
            begin
                sq_acc_reg <= {sq_acc_reg[49:0], 2'b00};
                if (sqrt_ge)
                begin
                    rem_reg  <= 28'(rem_sh - trial);
                    root_reg <= {root_reg[24:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[27:0];
                    root_reg <= {root_reg[24:0], 1'b0};
                end
            end
            ST_CHECK:
            begin
                dist_reg <= root_reg[24:0];
                nsh_reg  <= '0;
            end
            ST_NORM:
            begin
                if (dist_reg[RAD_W-1])
                begin
                    m_reg    <= {dist_reg, 6'b0};
                    frac_reg <= '0;
                end
                else
                begin
                    dist_reg <= {dist_reg[RAD_W-2:0], 1'b0};
                    nsh_reg  <= nsh_reg + 5'd1;
                end
            end
            ST_LOG_ACC:
            begin
                frac_reg <= {frac_reg[FRAC_W-2:0], log_t[31]};
                m_reg    <= log_t[31] ? log_t[31:1] : log_t[30:0];
            end
            ST_GCALC:
            begin
                gi_reg <= g_val[31:20];
                gf_reg <= g_val[19:4];
                m_reg  <= 31'h4000_0000;
            end
            ST_EXP_ACC:
            begin
                m_reg <= prod_reg[60:30];
            end
            ST_WEIGHT:
            begin
                w_reg <= w_calc;
            end
            ST_FINISH:
            begin
                neg_reg      <= wvs_reg[WVS_W-1];
                num_reg      <= {1'b0, wvs_abs} + {17'b0, wsum_reg[WSUM_W-1:1]};
                drem_reg     <= '0;
                res_miss_reg <= !exact_reg && (kept_reg == '0);
                res_est_reg  <= exact_reg ? exact_val_reg : '0;
            end
            ST_DIV:
            begin
                drem_reg <= div_ge ? 48'(div_rs - {1'b0, wsum_reg}) : div_rs[WSUM_W-1:0];
                num_reg  <= {num_reg[62:0], div_ge};
            end
            ST_ROUND:
            begin
                res_est_reg <= q_sat;
            end
            default:
            begin
            end
        endcase
    end

    a_exact_single: assert property (@(posedge clk) disable iff (!rst_n)
        exact_reg |-> (kept_reg == KEPT_W'(1)))
        else $error("exact hit with more than one neighbor");

    a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KEPT_W'(KEPT_CAP))
        else $error("kept count above cap");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_miss_reg) |-> (out_est_reg == '0))
        else $error("missing result with nonzero estimate");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != ST_EMIT))
        else $error("item taken straight into emit");
endmodule

>>> rtl/core/inverse_distance_interpolator.sv
// channel   dir  handshake      payload
// items     in   valid/ready    func, coord_x/y/z, sample_value, usable, last
// results   out  valid/ready    estimate, missing
// cfg       in   valid/ready    index, data (ready always high)
//
// a target item or a skipped point needs no work by the multiplier
// a kept point runs the per-dimension squares, root, normalize, log2
// and exp2 for its weight and value product on the one shared 32x32
// multiplier; a last item may add the bit-serial divide of the sums
// a two-entry queue lets items in while the back end works or a result waits
// rst_n clears sums, target and queue at once; no clearing pass
module inverse_distance_interpolator #(
    parameter int DIMENSIONS = idw_pkg::DEF_DIMENSIONS,
    parameter int MAX_POINTS = idw_pkg::DEF_MAX_POINTS
) (
    input  logic          clk,
    input  logic          rst_n,
    idw_item_if.sink      items,
    idw_result_if.source  results,
    idw_cfg_if.sink       cfg
);
    import idw_pkg::*;

    cfg_t         cfg_reg;
    queue_entry_t q_entry;
    logic         q_valid;
    logic         q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_exponent     <= POWER_RESET;
            cfg_reg.radius_enable      <= RADIUS_RESET;
            cfg_reg.max_radius         <= MAXR_RESET;
            cfg_reg.exact_hit_distance <= EHD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_POWER_EXPONENT: cfg_reg.power_exponent     <= cfg.data[PEXP_W-1:0];
                REG_RADIUS_ENABLE:  cfg_reg.radius_enable      <= cfg.data[0];
                REG_MAX_RADIUS:     cfg_reg.max_radius         <= cfg.data[RAD_W-1:0];
                REG_EXACT_HIT_DIST: cfg_reg.exact_hit_distance <= cfg.data[RAD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    idw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    idw_back #(
        .DIMENSIONS (DIMENSIONS),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .results (results)
    );
endmodule
